// ===== sv/pwfr_pkg.sv =====
// Shared widths, timing windows and defaults of the pulse width frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package pwfr_pkg;

   localparam int ChanW  = 2;
   localparam int TimeW  = 31;
   localparam int EnW    = 4;
   localparam int DataW  = 8;
   localparam int IndexW = 6;
   localparam int BitCntW = 3;

   // Receiver slots that exist at all; the channel field cannot name more.
   localparam int MaxSlots = 4;

   localparam int NUM_CHANNELS_DEF = 4;
   localparam int FRAME_BYTES_DEF  = 4;

   // Windows in microseconds.
   localparam logic [TimeW-1:0] HdrLowMin  = TimeW'(67 * 125);
   localparam logic [TimeW-1:0] HdrLowMax  = TimeW'(75 * 125);
   localparam logic [TimeW-1:0] HdrHighMin = TimeW'(30 * 125);
   localparam logic [TimeW-1:0] HdrHighMax = TimeW'(40 * 125);
   localparam logic [TimeW:0]   ZeroMin    = (TimeW + 1)'(6 * 125);
   localparam logic [TimeW:0]   ZeroMax    = (TimeW + 1)'(13 * 125);
   localparam logic [TimeW:0]   OneMin     = (TimeW + 1)'(15 * 125);
   localparam logic [TimeW:0]   OneMax     = (TimeW + 1)'(22 * 125);

endpackage
`default_nettype wire

// ===== sv/pwfr_req_if.sv =====
// Edge item channel of the pulse width frame receiver.
`timescale 1ns / 1ps
`default_nettype none
interface pwfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [pwfr_pkg::ChanW-1:0]   channel;
   logic                         pin_level;
   logic [pwfr_pkg::TimeW-1:0]   timestamp;

   modport source (output valid, output channel, output pin_level, output timestamp,
                   input ready);
   modport sink   (input valid, input channel, input pin_level, input timestamp,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/pwfr_rsp_if.sv =====
// Result item channel of the pulse width frame receiver.
`timescale 1ns / 1ps
`default_nettype none
interface pwfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          byte_valid;
   logic [pwfr_pkg::DataW-1:0]    data_byte;
   logic [pwfr_pkg::IndexW-1:0]   byte_index;
   logic                          frame_done;
   logic                          aborted;
   logic                          ignored;

   modport source (output valid, output byte_valid, output data_byte, output byte_index,
                   output frame_done, output aborted, output ignored, input ready);
   modport sink   (input valid, input byte_valid, input data_byte, input byte_index,
                   input frame_done, input aborted, input ignored, output ready);
endinterface
`default_nettype wire

// ===== sv/pwfr_csr_if.sv =====
// Channel enable write channel of the pulse width frame receiver.
`timescale 1ns / 1ps
`default_nettype none
interface pwfr_csr_if;
   logic                       valid;
   logic                       ready;
   logic [pwfr_pkg::EnW-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pulse_width_frame_receiver.sv =====
// Top level of the pulse width frame receiver: per-channel pulse distance decoding.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one pin edge item per clock (channel, level after the edge,
// 31-bit microsecond timestamp) and returns exactly one result item per edge,
// in order. Throughput is one item per cycle while results are taken as they
// come. An accepted item is held in the input register; from there the decode
// stage (one timestamp subtract, one low+high add and the window compares
// against the selected channel's state) loads the result register. A stalled
// result holds the input register, and then the input, until it is taken.
// A new item can follow in the next cycle on the same channel, since the
// channel state is updated on the same edge that loads the result. A frame
// starts with a low period of 8375..9375 us and a high period of 3750..5000 us;
// each following low+high pair is bit 0 (750..1625 us, exclusive) or bit 1
// (1875..2750 us, exclusive), first bit in bit zero. Every full byte is
// delivered with its index; after FRAME_BYTES bytes the channel's done flag
// sets (sticky until reset) and the channel waits for a new header. Write
// channel_enable only while the block is idle; edges on disabled channels, or
// on channels at or above NUM_CHANNELS, come back marked ignored.
module pulse_width_frame_receiver #(
   parameter int NUM_CHANNELS = pwfr_pkg::NUM_CHANNELS_DEF,
   parameter int FRAME_BYTES  = pwfr_pkg::FRAME_BYTES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pwfr_req_if.sink    req,
   pwfr_rsp_if.source  rsp,
   pwfr_csr_if.sink    csr
);

   localparam int NumSlots = (NUM_CHANNELS < pwfr_pkg::MaxSlots) ? NUM_CHANNELS
                                                                 : pwfr_pkg::MaxSlots;
   localparam int ByteW = $clog2(FRAME_BYTES + 1);
   localparam int TimeW = pwfr_pkg::TimeW;
   localparam int ChanW = pwfr_pkg::ChanW;
   localparam int DataW = pwfr_pkg::DataW;
   localparam int BitW  = pwfr_pkg::BitCntW;

   // Configuration
   logic [pwfr_pkg::EnW-1:0] enable_ff;

   // Input register
   logic              in_valid_ff;
   logic [ChanW-1:0]  in_ch_ff;
   logic              in_lvl_ff;
   logic [TimeW-1:0]  in_ts_ff;

   // Per-channel receiver state
   logic [TimeW-1:0]  last_ff  [NumSlots];
   logic [TimeW-1:0]  low_ff   [NumSlots];
   logic              seen_ff  [NumSlots];
   logic              frame_ff [NumSlots];
   logic [BitW-1:0]   bit_ff   [NumSlots];
   logic [ByteW-1:0]  byte_ff  [NumSlots];
   logic [DataW-1:0]  shift_ff [NumSlots];
   logic [NumSlots-1:0] done_ff;

   // Result register
   logic                          rsp_valid_ff;
   logic                          byte_valid_ff;
   logic [DataW-1:0]              data_ff;
   logic [pwfr_pkg::IndexW-1:0]   index_ff;
   logic                          done_out_ff;
   logic                          abort_ff;
   logic                          ignored_ff;

   // Selected channel state and its next value
   logic              advance;
   logic              in_range;
   logic              enabled;
   logic [TimeW-1:0]  cur_last;
   logic [TimeW-1:0]  cur_low;
   logic              cur_seen;
   logic              cur_frame;
   logic [BitW-1:0]   cur_bit;
   logic [ByteW-1:0]  cur_byte;
   logic [DataW-1:0]  cur_shift;
   logic              cur_done;
   logic [TimeW-1:0]  elapsed;
   logic [TimeW:0]    total;
   logic              low_ok;
   logic              high_ok;
   logic [TimeW-1:0]  low_in;
   logic              seen_in;
   logic              frame_in;
   logic [BitW-1:0]   bit_in;
   logic [ByteW-1:0]  byte_in;
   logic [DataW-1:0]  shift_in;
   logic              done_in;
   logic              byte_valid_in;
   logic [DataW-1:0]  data_in;
   logic [pwfr_pkg::IndexW-1:0] index_in;
   logic              done_out_in;
   logic              abort_in;

   // The decode stage moves when the result register is free or being taken.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (csr.valid) begin
         enable_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_ch_ff  <= req.channel;
         in_lvl_ff <= req.pin_level;
         in_ts_ff  <= req.timestamp;
      end
   end

   // Pick the addressed channel's state.
   always_comb begin
      in_range  = 32'(in_ch_ff) < NumSlots;
      cur_last  = '0;
      cur_low   = '0;
      cur_seen  = 1'b0;
      cur_frame = 1'b0;
      cur_bit   = '0;
      cur_byte  = '0;
      cur_shift = '0;
      cur_done  = 1'b0;
      for (int s = 0; s < NumSlots; s++) begin
         if (in_ch_ff == ChanW'(s)) begin
            cur_last  = last_ff[s];
            cur_low   = low_ff[s];
            cur_seen  = seen_ff[s];
            cur_frame = frame_ff[s];
            cur_bit   = bit_ff[s];
            cur_byte  = byte_ff[s];
            cur_shift = shift_ff[s];
            cur_done  = done_ff[s];
         end
      end
      enabled = in_range && enable_ff[in_ch_ff];
   end

   // Decode one edge.
   always_comb begin
      elapsed = in_ts_ff - cur_last;
      low_ok  = (cur_low >= pwfr_pkg::HdrLowMin) && (cur_low <= pwfr_pkg::HdrLowMax);
      high_ok = (elapsed >= pwfr_pkg::HdrHighMin) && (elapsed <= pwfr_pkg::HdrHighMax);
      total   = {1'b0, elapsed} + {1'b0, cur_low};

      low_in        = cur_low;
      seen_in       = cur_seen;
      frame_in      = cur_frame;
      bit_in        = cur_bit;
      byte_in       = cur_byte;
      shift_in      = cur_shift;
      done_in       = cur_done;
      byte_valid_in = 1'b0;
      data_in       = '0;
      index_in      = '0;
      abort_in      = 1'b0;

      if (in_lvl_ff) begin
         // Rising edge: a low period ends.
         low_in = elapsed;
         if (!cur_seen) begin
            seen_in = 1'b1;
            if (!cur_frame && !((elapsed >= pwfr_pkg::HdrLowMin) &&
                                (elapsed <= pwfr_pkg::HdrLowMax))) begin
               abort_in = 1'b1;
            end
         end
      end else if (cur_seen) begin
         // Falling edge: a high period ends.
         seen_in = 1'b0;
         if (!cur_frame) begin
            if (low_ok && high_ok) begin
               frame_in = 1'b1;
               bit_in   = '0;
               byte_in  = '0;
            end else begin
               abort_in = 1'b1;
            end
         end else begin
            shift_in = cur_shift >> 1;
            if ((total > pwfr_pkg::ZeroMin) && (total < pwfr_pkg::ZeroMax)) begin
               shift_in[DataW-1] = 1'b0;
            end else if ((total > pwfr_pkg::OneMin) && (total < pwfr_pkg::OneMax)) begin
               shift_in[DataW-1] = 1'b1;
            end else begin
               frame_in = 1'b0;
               abort_in = 1'b1;
            end
            if (frame_in) begin
               bit_in = cur_bit + 1'b1;
               if (bit_in == '0) begin
                  byte_valid_in = 1'b1;
                  data_in       = shift_in;
                  index_in      = pwfr_pkg::IndexW'(cur_byte);
                  byte_in       = cur_byte + 1'b1;
                  if (byte_in >= ByteW'(FRAME_BYTES)) begin
                     done_in  = 1'b1;
                     frame_in = 1'b0;
                  end
               end
            end
         end
      end

      done_out_in = enabled ? done_in : cur_done;
   end

   // Commit the channel state on the edge that loads the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NumSlots; s++) begin
            last_ff[s]  <= '0;
            low_ff[s]   <= '0;
            seen_ff[s]  <= 1'b0;
            frame_ff[s] <= 1'b0;
            bit_ff[s]   <= '0;
            byte_ff[s]  <= '0;
            shift_ff[s] <= '0;
         end
         done_ff <= '0;
      end else if (advance && enabled) begin
         for (int s = 0; s < NumSlots; s++) begin
            if (in_ch_ff == ChanW'(s)) begin
               last_ff[s]  <= in_ts_ff;
               low_ff[s]   <= low_in;
               seen_ff[s]  <= seen_in;
               frame_ff[s] <= frame_in;
               bit_ff[s]   <= bit_in;
               byte_ff[s]  <= byte_in;
               shift_ff[s] <= shift_in;
               done_ff[s]  <= done_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Disabled edges report only the current done flag.
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_valid_ff <= enabled && byte_valid_in;
         data_ff       <= enabled ? data_in : '0;
         index_ff      <= enabled ? index_in : '0;
         done_out_ff   <= done_out_in;
         abort_ff      <= enabled && abort_in;
         ignored_ff    <= !enabled;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.byte_valid = byte_valid_ff;
   assign rsp.data_byte  = data_ff;
   assign rsp.byte_index = index_ff;
   assign rsp.frame_done = done_out_ff;
   assign rsp.aborted    = abort_ff;
   assign rsp.ignored    = ignored_ff;

   // An accepted item sits in the input register on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> in_valid_ff)
      else $error("accepted item lost before decode");

   // An ignored edge carries neither a byte nor an abort.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ignored |-> !rsp.byte_valid && !rsp.aborted)
      else $error("ignored item reports activity");

   // A delivered byte never comes with an abort.
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.byte_valid |-> !rsp.aborted)
      else $error("byte delivered on aborted step");

   // Done flags never clear outside reset.
   assert property (@(posedge clock) disable iff (reset)
      (done_ff & $past(done_ff)) == $past(done_ff))
      else $error("sticky done flag cleared");

endmodule
`default_nettype wire
